// ===== design/s6ed_pkg.sv =====
package s6ed_pkg;

  localparam int S6ED_MAX_VERTEX_BITS = 36;
  localparam int VTX_W = 36;

  localparam logic [7:0] CH_LOW   = 8'h3f;
  localparam logic [7:0] CH_HIGH  = 8'h7e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam int         SIX_W    = 6;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_EDGE  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } s6ed_kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } s6ed_in_t;

  typedef struct packed {
    s6ed_kind_t       kind;
    logic [VTX_W-1:0] vertex_count;
    logic [VTX_W-1:0] edge_low;
    logic [VTX_W-1:0] edge_high;
    logic             final_of_run;
  } s6ed_out_t;

  typedef struct packed {
    logic push;
    logic flush;
  } s6ed_oq_ctl_t;

  typedef struct packed {
    logic push_ready;
    logic flush_done;
    logic pend_valid;
  } s6ed_oq_st_t;

endpackage

// ===== design/s6ed_outq.sv =====
module s6ed_outq
  import s6ed_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  s6ed_oq_ctl_t ctl_i,
  input  s6ed_out_t    push_data_i,
  output s6ed_oq_st_t  status_o,
  output logic         out_valid,
  input  logic         out_ready,
  output s6ed_out_t    out_data
);

  logic      pend_valid_r, pend_valid_nxt;
  s6ed_out_t pend_r, pend_nxt;
  logic      out_valid_r, out_valid_nxt;
  s6ed_out_t out_data_r, out_data_nxt;
  logic      slot_free;

  assign slot_free           = !out_valid_r || out_ready;
  assign status_o.push_ready = !pend_valid_r || slot_free;
  assign status_o.flush_done = !pend_valid_r || slot_free;
  assign status_o.pend_valid = pend_valid_r;
  assign out_valid           = out_valid_r;
  assign out_data            = out_data_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl_i.push && status_o.push_ready) begin
      if (pend_valid_r) begin
        out_data_nxt              = pend_r;
        out_data_nxt.final_of_run = 1'b0;
        out_valid_nxt             = 1'b1;
      end
      pend_nxt       = push_data_i;
      pend_valid_nxt = 1'b1;
    end else if (ctl_i.flush && pend_valid_r && slot_free) begin
      out_data_nxt              = pend_r;
      out_data_nxt.final_of_run = 1'b1;
      out_valid_nxt             = 1'b1;
      pend_valid_nxt            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/sparse6_edge_decoder_top.sv =====
// Decodes one sparse6 line per run of beats: a leading colon, the vertex count in its one-,
// four- or eight-byte form, then edge records read one bit per cycle from the six payload
// bits of each byte, except while an edge result waits for room in the output queue.
// Results leave in order as beats on the out channel, and the last result caused by an input
// byte carries final_of_run. The input is taken one byte at a time: a new byte is accepted
// only once the last one is fully handled, and the payload of a body byte is walked by the
// bit shifter. The decoder stalls while the out channel holds a result that is not taken
// and another one is due. The end of a line always returns an end-of-graph result, and
// the decoder then waits for the colon of the next line.
module sparse6_edge_decoder_top
  import s6ed_pkg::*;
#(
  parameter int MAX_VERTEX_BITS = S6ED_MAX_VERTEX_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  s6ed_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output s6ed_out_t out_data
);

  localparam int VW = MAX_VERTEX_BITS;

  typedef enum logic [6:0] {
    PH_COLON  = 7'b0000001,
    PH_FIRST  = 7'b0000010,
    PH_SECOND = 7'b0000100,
    PH_HEADER = 7'b0001000,
    PH_BODY   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_ERROR  = 7'b1000000
  } s6ed_phase_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_BYTE    = 6'b000010,
    ST_BITS    = 6'b000100,
    ST_EOL_ERR = 6'b001000,
    ST_EOL_END = 6'b010000,
    ST_FLUSH   = 6'b100000
  } s6ed_state_t;

  s6ed_state_t state_r, state_nxt;
  s6ed_phase_t phase_r, phase_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        eol_r, eol_nxt;
  logic [2:0]  hdr_left_r, hdr_left_nxt;
  logic [VW-1:0] ntot_r, ntot_nxt;
  logic [VW-1:0] m_r, m_nxt;
  logic [VW-1:0] mrem_r, mrem_nxt;
  logic [VW-1:0] xbuf_r, xbuf_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic        rec_x_r, rec_x_nxt;
  logic [SIX_W-1:0] six_r, six_nxt;
  logic [2:0]  bitcnt_r, bitcnt_nxt;

  logic             ch_ok;
  logic [SIX_W-1:0] six;
  logic             bit_in;
  logic [VW-1:0]    v_inc;
  logic [VW-1:0]    x_new;
  logic [VW-1:0]    mrem_sh;
  logic             hdr_done;
  logic             eol_err_due;
  logic             step_emit;
  logic [VW-1:0]    step_lo;
  logic [VW-1:0]    step_hi;

  s6ed_oq_ctl_t oq_ctl;
  s6ed_oq_st_t  oq_st;
  s6ed_out_t    push_data;

  assign ch_ok   = (char_r >= CH_LOW) && (char_r <= CH_HIGH);
  assign six     = SIX_W'(char_r - CH_LOW);
  assign bit_in  = six_r[SIX_W-1];
  assign v_inc   = v_r + VW'(bit_in);
  assign x_new   = VW'({xbuf_r, bit_in});
  assign mrem_sh = mrem_r >> 1;
  assign in_ready = (state_r == ST_IDLE);
  assign eol_err_due = (phase_r == PH_COLON) || (phase_r == PH_FIRST) ||
                       (phase_r == PH_SECOND) || (phase_r == PH_HEADER);

  always_comb begin
    step_emit = 1'b0;
    step_lo   = '0;
    step_hi   = '0;
    if (phase_r == PH_BODY) begin
      if (!rec_x_r) begin
        if ((v_inc < ntot_r) && (m_r == '0)) begin
          step_emit = 1'b1;
          step_hi   = v_inc;
        end
      end else if ((mrem_sh == '0) && (x_new < ntot_r) && (x_new <= v_r)) begin
        step_emit = 1'b1;
        step_lo   = x_new;
        step_hi   = v_r;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    char_nxt     = char_r;
    eol_nxt      = eol_r;
    hdr_left_nxt = hdr_left_r;
    ntot_nxt     = ntot_r;
    m_nxt        = m_r;
    mrem_nxt     = mrem_r;
    xbuf_nxt     = xbuf_r;
    v_nxt        = v_r;
    rec_x_nxt    = rec_x_r;
    six_nxt      = six_r;
    bitcnt_nxt   = bitcnt_r;
    hdr_done     = 1'b0;
    oq_ctl       = '0;
    push_data              = '0;
    push_data.vertex_count = VTX_W'(ntot_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_data.char_byte;
          eol_nxt   = in_data.end_of_line;
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (oq_st.push_ready) begin
          state_nxt = eol_r ? ST_EOL_ERR : ST_FLUSH;
          if (phase_r == PH_COLON) begin
            if (char_r == CH_COLON) begin
              phase_nxt = PH_FIRST;
            end else begin
              phase_nxt      = PH_ERROR;
              oq_ctl.push    = 1'b1;
              push_data.kind = KIND_ERROR;
            end
          end else if ((phase_r != PH_ERROR) && !ch_ok) begin
            phase_nxt      = PH_ERROR;
            oq_ctl.push    = 1'b1;
            push_data.kind = KIND_ERROR;
          end else begin
            unique case (phase_r)
              PH_FIRST: begin
                if (char_r == CH_HIGH) begin
                  phase_nxt = PH_SECOND;
                end else begin
                  ntot_nxt = VW'(six);
                  hdr_done = 1'b1;
                end
              end
              PH_SECOND: begin
                if (char_r == CH_HIGH) begin
                  hdr_left_nxt = 3'd6;
                  ntot_nxt     = '0;
                end else begin
                  hdr_left_nxt = 3'd2;
                  ntot_nxt     = VW'(six);
                end
                phase_nxt = PH_HEADER;
              end
              PH_HEADER: begin
                ntot_nxt     = VW'({ntot_r, six});
                hdr_left_nxt = hdr_left_r - 3'd1;
                if (hdr_left_r == 3'd1) begin
                  hdr_done = 1'b1;
                end
              end
              PH_BODY: begin
                six_nxt    = six;
                bitcnt_nxt = '0;
                state_nxt  = ST_BITS;
              end
              default: begin
              end
            endcase
          end
          if (hdr_done) begin
            m_nxt                  = ntot_nxt - VW'(1);
            v_nxt                  = '0;
            rec_x_nxt              = 1'b0;
            xbuf_nxt               = '0;
            phase_nxt              = PH_BODY;
            oq_ctl.push            = 1'b1;
            push_data.kind         = KIND_COUNT;
            push_data.vertex_count = VTX_W'(ntot_nxt);
          end
        end
      end
      ST_BITS: begin
        if (!step_emit || oq_st.push_ready) begin
          if (phase_r == PH_BODY) begin
            if (!rec_x_r) begin
              v_nxt = v_inc;
              if (v_inc >= ntot_r) begin
                phase_nxt = PH_DONE;
              end else if (m_r != '0) begin
                rec_x_nxt = 1'b1;
                xbuf_nxt  = '0;
                mrem_nxt  = m_r;
              end
            end else begin
              xbuf_nxt = x_new;
              mrem_nxt = mrem_sh;
              if (mrem_sh == '0) begin
                rec_x_nxt = 1'b0;
                xbuf_nxt  = '0;
                if (x_new >= ntot_r) begin
                  phase_nxt = PH_DONE;
                end else if (x_new > v_r) begin
                  v_nxt = x_new;
                end
              end
            end
          end
          if (step_emit) begin
            oq_ctl.push        = 1'b1;
            push_data.kind     = KIND_EDGE;
            push_data.edge_low  = VTX_W'(step_lo);
            push_data.edge_high = VTX_W'(step_hi);
          end
          six_nxt    = {six_r[SIX_W-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r + 3'd1;
          if (bitcnt_r == 3'(SIX_W - 1)) begin
            state_nxt = eol_r ? ST_EOL_ERR : ST_FLUSH;
          end
        end
      end
      ST_EOL_ERR: begin
        if (!eol_err_due) begin
          state_nxt = ST_EOL_END;
        end else if (oq_st.push_ready) begin
          oq_ctl.push    = 1'b1;
          push_data.kind = KIND_ERROR;
          state_nxt      = ST_EOL_END;
        end
      end
      ST_EOL_END: begin
        if (oq_st.push_ready) begin
          oq_ctl.push    = 1'b1;
          push_data.kind = KIND_END;
          phase_nxt      = PH_COLON;
          hdr_left_nxt   = '0;
          ntot_nxt       = '0;
          m_nxt          = '0;
          mrem_nxt       = '0;
          xbuf_nxt       = '0;
          v_nxt          = '0;
          rec_x_nxt      = 1'b0;
          state_nxt      = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        oq_ctl.flush = 1'b1;
        if (oq_st.flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      phase_r    <= PH_COLON;
      hdr_left_r <= '0;
      ntot_r     <= '0;
      m_r        <= '0;
      mrem_r     <= '0;
      xbuf_r     <= '0;
      v_r        <= '0;
      rec_x_r    <= 1'b0;
      bitcnt_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      hdr_left_r <= hdr_left_nxt;
      ntot_r     <= ntot_nxt;
      m_r        <= m_nxt;
      mrem_r     <= mrem_nxt;
      xbuf_r     <= xbuf_nxt;
      v_r        <= v_nxt;
      rec_x_r    <= rec_x_nxt;
      bitcnt_r   <= bitcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    eol_r  <= eol_nxt;
    six_r  <= six_nxt;
  end

  s6ed_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (oq_ctl),
    .push_data_i (push_data),
    .status_o    (oq_st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !oq_st.pend_valid)
    else $error("A result is still held back while a new byte can be taken.");

  a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_EDGE) |-> out_data.edge_low <= out_data.edge_high)
    else $error("An edge beat has its low endpoint above its high endpoint.");

  a_vertex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY && rec_x_r) |-> v_r < ntot_r)
    else $error("The current vertex reached the vertex count inside a record.");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import s6ed_pkg::*;

  typedef enum logic [2:0] {
    PH_COLON,
    PH_FIRST,
    PH_SECOND,
    PH_HEADER,
    PH_BODY,
    PH_DONE,
    PH_ERROR
  } line_phase_t;

  typedef struct {
    logic [7:0]   ch;
    logic         eol;
    bit           typed;
    int unsigned  n_typed;
    s6ed_kind_t   k0;
    s6ed_kind_t   k1;
    logic [35:0]  vc;
  } beat_row_t;

  localparam int unsigned RANDOM_BEATS = 343;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam logic [35:0] N_MAX        = 36'hfffffffff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  s6ed_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  s6ed_out_t out_data;

  bit          steady;
  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned idle_cycles;
  int unsigned lines_seen;
  int unsigned edges_seen;
  int unsigned counts_seen;
  int unsigned format_errors_seen;

  line_phase_t line_phase;
  logic [2:0]  hdr_left;
  logic [35:0] n_total;
  int unsigned k_bits;
  logic [35:0] idx_acc;
  int unsigned idx_got;
  logic [35:0] cur_v;
  bit          in_record;

  s6ed_out_t fresh_results[$];
  s6ed_out_t results_due[$];

  // The directed beats, with the results typed in where they are plain to see.
  beat_row_t dir_rows [27] = '{
    '{8'h00,    1'b0, 1'b1, 1, KIND_ERROR, KIND_END, 36'h0},
    '{8'hff,    1'b1, 1'b1, 1, KIND_END,   KIND_END, 36'h0},
    '{CH_COLON, 1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h3f,    1'b0, 1'b1, 1, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b1, 1'b1, 1, KIND_END,   KIND_END, 36'h0},
    '{CH_COLON, 1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 1, KIND_COUNT, KIND_END, N_MAX},
    '{8'h40,    1'b0, 1'b0, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'hff,    1'b0, 1'b1, 1, KIND_ERROR, KIND_END, N_MAX},
    '{8'h00,    1'b1, 1'b1, 1, KIND_END,   KIND_END, N_MAX},
    '{CH_COLON, 1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h61,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h3f,    1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h3f,    1'b1, 1'b1, 2, KIND_COUNT, KIND_END, 36'h22000},
    '{CH_COLON, 1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h7e,    1'b1, 1'b1, 2, KIND_ERROR, KIND_END, 36'h0},
    '{CH_COLON, 1'b0, 1'b1, 0, KIND_COUNT, KIND_END, 36'h0},
    '{8'h40,    1'b0, 1'b1, 1, KIND_COUNT, KIND_END, 36'h1},
    '{8'h3f,    1'b1, 1'b0, 0, KIND_COUNT, KIND_END, 36'h0}
  };

  sparse6_edge_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void line_clear();
    line_phase = PH_COLON;
    hdr_left   = '0;
    n_total    = '0;
    k_bits     = 0;
    idx_acc    = '0;
    idx_got    = 0;
    cur_v      = '0;
    in_record  = 1'b0;
  endfunction

  function automatic void note_result(s6ed_kind_t k, logic [35:0] lo, logic [35:0] hi);
    s6ed_out_t r;
    r.kind         = k;
    r.vertex_count = n_total;
    r.edge_low     = lo;
    r.edge_high    = hi;
    r.final_of_run = 1'b0;
    fresh_results.push_back(r);
  endfunction

  function automatic void count_known();
    logic [35:0] m;
    m = n_total - 36'd1;
    k_bits = 0;
    while (m != 0) begin
      k_bits++;
      m = m >> 1;
    end
    cur_v      = '0;
    idx_acc    = '0;
    idx_got    = 0;
    in_record  = 1'b0;
    line_phase = PH_BODY;
    note_result(KIND_COUNT, '0, '0);
  endfunction

  function automatic void close_record(logic [35:0] x);
    in_record = 1'b0;
    idx_acc   = '0;
    idx_got   = 0;
    if (x >= n_total) begin
      line_phase = PH_DONE;
    end else if (x > cur_v) begin
      cur_v = x;
    end else begin
      note_result(KIND_EDGE, x, cur_v);
    end
  endfunction

  // Works out the results that one input byte causes, in order.
  function automatic void decode_byte(logic [7:0] ch, logic eol);
    logic       legal;
    logic [5:0] six;
    legal = (ch >= CH_LOW) && (ch <= CH_HIGH);
    six   = 6'(ch - CH_LOW);
    fresh_results.delete();
    if (line_phase == PH_COLON) begin
      if (ch == CH_COLON) begin
        line_phase = PH_FIRST;
      end else begin
        line_phase = PH_ERROR;
        note_result(KIND_ERROR, '0, '0);
      end
    end else if (line_phase != PH_ERROR && !legal) begin
      line_phase = PH_ERROR;
      note_result(KIND_ERROR, '0, '0);
    end else if (line_phase == PH_FIRST) begin
      if (ch == CH_HIGH) begin
        line_phase = PH_SECOND;
      end else begin
        n_total = 36'(six);
        count_known();
      end
    end else if (line_phase == PH_SECOND) begin
      if (ch == CH_HIGH) begin
        hdr_left = 3'd6;
        n_total  = '0;
      end else begin
        hdr_left = 3'd2;
        n_total  = 36'(six);
      end
      line_phase = PH_HEADER;
    end else if (line_phase == PH_HEADER) begin
      n_total = {n_total[29:0], six};
      if (hdr_left > 0) hdr_left--;
      if (hdr_left == 0) count_known();
    end else if (line_phase == PH_BODY) begin
      for (int i = 5; i >= 0; i--) begin
        if (line_phase == PH_BODY) begin
          if (!in_record) begin
            if (six[i]) cur_v++;
            if (cur_v >= n_total) begin
              line_phase = PH_DONE;
            end else if (k_bits == 0) begin
              close_record('0);
            end else begin
              in_record = 1'b1;
              idx_acc   = '0;
              idx_got   = 0;
            end
          end else begin
            idx_acc = {idx_acc[34:0], six[i]};
            idx_got++;
            if (idx_got >= k_bits) close_record(idx_acc);
          end
        end
      end
    end
    if (eol) begin
      if (line_phase inside {PH_COLON, PH_FIRST, PH_SECOND, PH_HEADER}) begin
        note_result(KIND_ERROR, '0, '0);
      end
      note_result(KIND_END, '0, '0);
      line_clear();
    end
    if (fresh_results.size() > 0) fresh_results[$].final_of_run = 1'b1;
  endfunction

  task automatic send_beat(input beat_row_t row);
    s6ed_out_t r;
    if (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_byte: row.ch, end_of_line: row.eol};
    do @(posedge clk); while (!in_ready);
    decode_byte(row.ch, row.eol);
    if (row.typed) begin
      for (int i = 0; i < row.n_typed; i++) begin
        r.kind         = (i == 0) ? row.k0 : row.k1;
        r.vertex_count = row.vc;
        r.edge_low     = '0;
        r.edge_high    = '0;
        r.final_of_run = (i == row.n_typed - 1);
        results_due.push_back(r);
      end
    end else begin
      foreach (fresh_results[i]) results_due.push_back(fresh_results[i]);
    end
    beats_sent++;
  endtask

  function automatic logic [7:0] any_legal();
    return 8'(CH_LOW + $urandom_range(0, 63));
  endfunction

  // Mostly well-formed lines with random content; the rest are broken or junk.
  task automatic send_random_line();
    logic [7:0]  seq[$];
    int unsigned mode;
    int unsigned form;
    int unsigned hdr_len;
    bit          junk;
    beat_row_t   row;
    mode = $urandom_range(99);
    junk = (mode >= 16 && mode < 20);
    if (mode < 4) begin
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      seq.push_back(CH_COLON);
    end
    form = $urandom_range(99);
    if (form < 70) begin
      if ($urandom_range(3) == 0) begin
        seq.push_back(8'(CH_LOW + $urandom_range(0, 62)));
      end else begin
        seq.push_back(8'(CH_LOW + $urandom_range(1, 12)));
      end
    end else if (form < 85) begin
      seq.push_back(CH_HIGH);
      seq.push_back(($urandom_range(2) == 0) ? 8'(CH_LOW + $urandom_range(0, 62)) : CH_LOW);
      seq.push_back(($urandom_range(2) == 0) ? any_legal() : CH_LOW);
      seq.push_back(any_legal());
    end else begin
      seq.push_back(CH_HIGH);
      seq.push_back(CH_HIGH);
      for (int i = 0; i < 5; i++) begin
        seq.push_back(($urandom_range(3) == 0) ? any_legal() : CH_LOW);
      end
      seq.push_back(any_legal());
    end
    hdr_len = seq.size();
    repeat ($urandom_range(0, 10)) seq.push_back(any_legal());
    if (mode >= 4 && mode < 12) begin
      seq.insert($urandom_range(1, seq.size()),
                 $urandom_range(1) ? 8'($urandom_range(0, 62)) : 8'($urandom_range(127, 255)));
    end else if (mode >= 12 && mode < 16) begin
      while (seq.size() > $urandom_range(1, hdr_len - 1)) void'(seq.pop_back());
    end else if (junk) begin
      seq.delete();
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end
    row.typed   = 1'b0;
    row.n_typed = 0;
    row.k0      = KIND_COUNT;
    row.k1      = KIND_COUNT;
    row.vc      = '0;
    foreach (seq[i]) begin
      row.ch  = seq[i];
      row.eol = (i == seq.size() - 1) || (junk && $urandom_range(4) == 0);
      send_beat(row);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 22);
  end

  function automatic void field_check(string name, logic [35:0] want, logic [35:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    s6ed_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        field_check("kind", 36'(want.kind), 36'(out_data.kind));
        field_check("vertex_count", want.vertex_count, out_data.vertex_count);
        field_check("edge_low", want.edge_low, out_data.edge_low);
        field_check("edge_high", want.edge_high, out_data.edge_high);
        field_check("final_of_run", 36'(want.final_of_run), 36'(out_data.final_of_run));
        case (out_data.kind)
          KIND_COUNT: counts_seen++;
          KIND_EDGE:  edges_seen++;
          KIND_END:   lines_seen++;
          default:    format_errors_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned line_no;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    steady      = 1'b0;
    fail_count  = 0;
    beats_sent  = 0;
    idle_cycles = 0;
    line_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    line_no = 0;
    while (beats_sent < $size(dir_rows) + RANDOM_BEATS) begin
      steady = (line_no >= 12 && line_no < 22);
      send_random_line();
      line_no++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d beats over %0d lines; checked %0d edges, %0d vertex counts,",
             beats_sent, lines_seen, edges_seen, counts_seen);
    $display("%0d format errors and %0d end-of-graph results.", format_errors_seen, lines_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/s6ed_pkg.sv
design/s6ed_outq.sv
design/sparse6_edge_decoder_top.sv
tb/tb_top.sv
